/* hw/rtl/frag_pkg.sv */
package frag_pkg;

  // frame header layout
  localparam int HEADER_BYTES = 7;
  localparam logic [2:0] HDR_LAST = 3'(HEADER_BYTES - 1);

  // byte position within a frame, saturating
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // smallest usable mtu and its reset value
  localparam logic [15:0] MTU_FLOOR = 16'd8;
  localparam logic [15:0] MTU_RESET = 16'd64;

  // fragment count divider: one quotient bit per cycle
  localparam int DIV_W = 17;
  localparam logic [4:0] DIV_STEPS = 5'(DIV_W);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_UNIT     = 2'd0,
    REG_DELIM_FIRST  = 2'd1,
    REG_DELIM_SECOND = 2'd2
  } frag_reg_e;

  // fragment header byte positions
  typedef enum logic [2:0] {
    FH_DELIM_A   = 3'd0,
    FH_DELIM_B   = 3'd1,
    FH_PACKET_ID = 3'd2,
    FH_INDEX     = 3'd3,
    FH_MORE      = 3'd4,
    FH_LEN_LO    = 3'd5,
    FH_LEN_HI    = 3'd6
  } frag_field_e;

  // input item
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frag_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       fragment_end;
    logic       count_overflow;
    logic       run_last;
  } frag_out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIVIDE,
    ST_EMIT_HELD,
    ST_EMIT_FHDR,
    ST_EMIT_BYTE
  } frag_state_t;

  // output byte source
  typedef enum logic [1:0] {
    SRC_HELD,
    SRC_FHDR,
    SRC_BYTE
  } frag_src_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      emit_start;
    logic      emit_adv;
    logic      set_pass;
    logic      div_start;
    logic      div_step;
    logic      div_done;
    logic      frag_start;
    logic      out_load;
    frag_src_t out_src;
    logic      byte_done;
    logic      finish;
  } frag_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr_partial;
    logic hdr_last;
    logic frame_fits;
    logic passthrough;
    logic frag_take;
    logic chunk_zero;
    logic item_end;
    logic emit_last;
    logic div_zero;
    logic out_free;
  } frag_stat_t;

endpackage

/* hw/rtl/frag_ctrl.sv */
module frag_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  frag_pkg::frag_stat_t stat,
  output frag_pkg::frag_cmd_t  cmd,
  output logic                in_ready
);
  import frag_pkg::*;

  frag_state_t state;
  frag_state_t state_next;

  // true when the decoded item is a single byte going straight out
  logic single_byte;
  assign single_byte = stat.passthrough || (stat.frag_take && !stat.chunk_zero);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.hdr_partial) begin
          state_next = stat.item_end ? ST_EMIT_HELD : ST_IDLE;
        end else if (stat.hdr_last) begin
          if (stat.frame_fits) begin
            state_next = ST_EMIT_HELD;
          end else if (stat.item_end) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DIVIDE;
          end
        end else if (single_byte) begin
          state_next = stat.out_free ? ST_IDLE : ST_EMIT_BYTE;
        end else if (stat.frag_take) begin
          state_next = ST_EMIT_FHDR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (stat.div_zero) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_HELD: begin
        if (stat.out_free && stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_FHDR: begin
        if (stat.out_free && stat.emit_last) begin
          state_next = ST_EMIT_BYTE;
        end
      end
      ST_EMIT_BYTE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.out_src = SRC_BYTE;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DECODE: begin
        if (stat.hdr_partial) begin
          if (stat.item_end) begin
            cmd.emit_start = 1'b1;
          end else begin
            cmd.finish = 1'b1;
          end
        end else if (stat.hdr_last) begin
          if (stat.frame_fits) begin
            cmd.set_pass   = 1'b1;
            cmd.emit_start = 1'b1;
          end else if (stat.item_end) begin
            cmd.finish = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
          end
        end else if (single_byte) begin
          if (stat.out_free) begin
            cmd.out_load  = 1'b1;
            cmd.out_src   = SRC_BYTE;
            cmd.byte_done = 1'b1;
            cmd.finish    = 1'b1;
          end
        end else if (stat.frag_take) begin
          cmd.frag_start = 1'b1;
          cmd.emit_start = 1'b1;
        end else begin
          cmd.finish = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (stat.div_zero) begin
          cmd.div_done = 1'b1;
          cmd.finish   = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT_HELD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_HELD;
          cmd.finish   = stat.emit_last;
          cmd.emit_adv = !stat.emit_last;
        end
      end
      ST_EMIT_FHDR: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_FHDR;
          cmd.emit_adv = !stat.emit_last;
        end
      end
      ST_EMIT_BYTE: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_src   = SRC_BYTE;
          cmd.byte_done = 1'b1;
          cmd.finish    = 1'b1;
        end
      end
      default: begin
        cmd = '0;
        cmd.out_src = SRC_BYTE;
      end
    endcase
  end

endmodule

/* hw/rtl/frag_dp.sv */
module frag_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  frag_pkg::frag_cmd_t  cmd,
  output frag_pkg::frag_stat_t stat,
  input  frag_pkg::frag_in_t   in_data,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output frag_pkg::frag_out_t  out_data
);
  import frag_pkg::*;

  // configuration
  logic [15:0] max_unit_size;
  logic [7:0]  delimiter_first;
  logic [7:0]  delimiter_second;

  // frame state
  logic [7:0]       header_store [HEADER_BYTES];
  logic [POS_W-1:0] byte_position;
  logic [15:0]      payload_length;
  logic [15:0]      chunk_position;
  logic [7:0]       fragment_index;
  logic [7:0]       fragment_total;
  logic             passthrough_mode;
  logic [15:0]      chunk_size;
  logic [15:0]      current_len;
  logic             overflow_bit;

  // current item
  logic [7:0] item_byte;
  logic       item_end;

  // emit sequencing
  logic [2:0] emit_cnt;
  logic [2:0] emit_limit;

  // divider
  logic [DIV_W-1:0] div_quo;
  logic [15:0]      div_rem;
  logic [4:0]       div_cnt;

  // derived values
  logic [15:0]      mtu_eff;
  logic [15:0]      chunk_new;
  logic [15:0]      hdr_length;
  logic [POS_W-1:0] payload_pos;
  logic [15:0]      remaining;
  logic [DIV_W-1:0] div_shift;
  logic [DIV_W-1:0] div_diff;
  logic             div_ge;
  logic [15:0]      chunk_pos_inc;
  logic             chunk_full;
  logic             in_header;
  frag_out_t        out_sel;

  assign mtu_eff     = (max_unit_size < MTU_FLOOR) ? MTU_FLOOR : max_unit_size;
  assign chunk_new   = mtu_eff - 16'(HEADER_BYTES);
  assign hdr_length  = {header_store[6], header_store[5]};
  assign payload_pos = byte_position - POS_W'(HEADER_BYTES);
  assign remaining   = payload_length - payload_pos[15:0];
  assign div_shift   = {div_rem, div_quo[DIV_W-1]};
  assign div_diff    = div_shift - {1'b0, chunk_size};
  assign div_ge      = div_shift >= {1'b0, chunk_size};
  assign chunk_pos_inc = chunk_position + 16'd1;
  assign chunk_full    = chunk_pos_inc >= current_len;
  assign in_header     = byte_position < POS_W'(HEADER_BYTES);

  // status toward the controller
  always_comb begin
    stat.hdr_partial = byte_position < POS_W'(HDR_LAST);
    stat.hdr_last    = byte_position == POS_W'(HDR_LAST);
    stat.frame_fits  = ({1'b0, hdr_length} + 17'(HEADER_BYTES)) <= {1'b0, mtu_eff};
    stat.passthrough = passthrough_mode;
    stat.frag_take   = (payload_pos < {1'b0, payload_length}) &&
                       (fragment_index < fragment_total);
    stat.chunk_zero  = chunk_position == 16'd0;
    stat.item_end    = item_end;
    stat.emit_last   = emit_cnt == emit_limit;
    stat.div_zero    = div_cnt == 5'd0;
    stat.out_free    = !out_valid || out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_unit_size    <= MTU_RESET;
      delimiter_first  <= 8'd0;
      delimiter_second <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_UNIT:     max_unit_size    <= cfg_data;
        REG_DELIM_FIRST:  delimiter_first  <= cfg_data[7:0];
        REG_DELIM_SECOND: delimiter_second <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item latch and header capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_byte <= in_data.frame_byte;
      item_end  <= in_data.frame_end;
      if (in_header) begin
        header_store[byte_position[2:0]] <= in_data.frame_byte;
      end
    end
  end

  // emit counter
  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emit_cnt   <= 3'd0;
      emit_limit <= in_header ? byte_position[2:0] : HDR_LAST;
    end else if (cmd.emit_adv) begin
      emit_cnt <= emit_cnt + 3'd1;
    end
  end

  // fragment count divider, restoring, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 5'd0;
    end else if (cmd.div_start) begin
      div_quo <= {1'b0, hdr_length} + {1'b0, chunk_new} - 17'd1;
      div_rem <= 16'd0;
      div_cnt <= DIV_STEPS;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 5'd1;
      if (div_ge) begin
        div_rem <= div_diff[15:0];
        div_quo <= {div_quo[DIV_W-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[15:0];
        div_quo <= {div_quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // per-frame state; a frame end clears it all
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      payload_length   <= '0;
      chunk_position   <= '0;
      fragment_index   <= '0;
      fragment_total   <= '0;
      passthrough_mode <= 1'b0;
      chunk_size       <= '0;
      current_len      <= '0;
      overflow_bit     <= 1'b0;
    end else begin
      if (cmd.set_pass) begin
        passthrough_mode <= 1'b1;
        payload_length   <= hdr_length;
      end
      if (cmd.div_start) begin
        passthrough_mode <= 1'b0;
        payload_length   <= hdr_length;
        chunk_size       <= chunk_new;
      end
      if (cmd.div_done) begin
        overflow_bit   <= |div_quo[DIV_W-1:8];
        fragment_total <= div_quo[7:0];
        chunk_position <= 16'd0;
        fragment_index <= 8'd0;
      end
      if (cmd.frag_start) begin
        current_len <= (remaining < chunk_size) ? remaining : chunk_size;
      end
      if (cmd.byte_done && !passthrough_mode) begin
        if (chunk_full) begin
          chunk_position <= 16'd0;
          fragment_index <= fragment_index + 8'd1;
        end else begin
          chunk_position <= chunk_pos_inc;
        end
      end
      if (cmd.finish) begin
        if (item_end) begin
          byte_position    <= '0;
          payload_length   <= '0;
          chunk_position   <= '0;
          fragment_index   <= '0;
          fragment_total   <= '0;
          passthrough_mode <= 1'b0;
          chunk_size       <= '0;
          current_len      <= '0;
          overflow_bit     <= 1'b0;
        end else if (byte_position != POS_MAX) begin
          byte_position <= byte_position + POS_W'(1);
        end
      end
    end
  end

  // output byte selection
  always_comb begin
    out_sel = '0;
    case (cmd.out_src)
      SRC_HELD: begin
        out_sel.out_byte     = header_store[emit_cnt];
        out_sel.fragment_end = stat.emit_last && item_end;
        out_sel.run_last     = stat.emit_last;
      end
      SRC_FHDR: begin
        out_sel.count_overflow = overflow_bit;
        case (emit_cnt)
          FH_DELIM_A:   out_sel.out_byte = delimiter_first;
          FH_DELIM_B:   out_sel.out_byte = delimiter_second;
          FH_PACKET_ID: out_sel.out_byte = header_store[2];
          FH_INDEX:     out_sel.out_byte = fragment_index;
          FH_MORE:      out_sel.out_byte =
                          (fragment_index == fragment_total - 8'd1) ? 8'd0 : 8'd1;
          FH_LEN_LO:    out_sel.out_byte = current_len[7:0];
          FH_LEN_HI:    out_sel.out_byte = current_len[15:8];
          default:      out_sel.out_byte = 8'd0;
        endcase
      end
      SRC_BYTE: begin
        out_sel.out_byte = item_byte;
        out_sel.run_last = 1'b1;
        if (passthrough_mode) begin
          out_sel.fragment_end = item_end;
        end else begin
          out_sel.fragment_end   = (chunk_pos_inc == current_len) || item_end;
          out_sel.count_overflow = overflow_bit;
        end
      end
      default: out_sel = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_sel;
    end
  end

endmodule

/* hw/rtl/frame_fragmenter.sv */
// Frame fragmenter: takes a frame one byte per item (7-byte header, then the
// payload) and either passes it through whole or re-emits the payload in
// chunks of max_unit_size - 7 bytes (max_unit_size read as at least 8), each
// behind a fresh 7-byte header. Each item is accepted in the idle state and
// then decoded. A plain or payload byte leaves in the decode state when the
// output register is free. Other results follow decode: a frame end inside
// the header re-emits the held header bytes, the last header byte of a frame
// passed whole emits the header, and the byte that opens a fragment emits a
// fragment header before itself. When the last header byte of a frame that
// must be fragmented arrives, the fragment count comes from a bit-serial
// divider. An output register holds the pending result, so a stalled output
// only stalls the block when the next result is ready to go. Configuration
// writes are always accepted and belong between frames.
module frame_fragmenter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  frag_pkg::frag_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output frag_pkg::frag_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import frag_pkg::*;

  frag_cmd_t  cmd;
  frag_stat_t stat;

  // configuration writes are never stalled
  assign cfg_ready = 1'b1;

  // sequencing
  frag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // frame state, divider and output register
  frag_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/frag_checker.sv */
module frag_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input frag_pkg::frag_out_t out_data
);
  import frag_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every item passes through decode before the next one is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  // more results of the same item are pending, so no new item is taken
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.run_last |-> !in_ready)
    else $error("input ready while an item's results are open");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind frame_fragmenter frag_checker u_frag_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
